@@ sv/linear_probe_hash_table_assert.svh @@
// Assertion macros shared by the hash table RTL
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define LPHT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define LPHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/lpht_pkg.sv @@
// Types, constants and codes shared by the hash table modules
`timescale 1ns / 1ps

package lpht_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int SLOT_W      = $clog2(TABLE_DEPTH);
   localparam int SIZE_W      = SLOT_W + 1;
   localparam int KEY_W       = 31;
   localparam int ID_W        = 31;
   localparam int AGE_W       = 8;
   localparam int REQ_W       = 2;
   localparam int STATUS_W    = 2;
   localparam int CNT_W       = $clog2(KEY_W);

   typedef enum logic [REQ_W-1:0] {
      REQ_INSERT = 2'd0,
      REQ_SEARCH = 2'd1,
      REQ_DELETE = 2'd2
   } req_kind_type;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd2;

   typedef struct packed {
      logic [REQ_W-1:0] req_type;
      logic [KEY_W-1:0] key;
      logic [ID_W-1:0]  id_value;
      logic [AGE_W-1:0] age_value;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot_index;
      logic [ID_W-1:0]     found_id;
      logic [AGE_W-1:0]    found_age;
   } rsp_word_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [ID_W-1:0]  id;
      logic [AGE_W-1:0] age;
   } slot_entry_type;

   typedef struct packed {
      logic             en;
      logic [SLOT_W-1:0] addr;
      slot_entry_type   data;
   } ram_wr_type;

   typedef struct packed {
      logic              start;
      logic [KEY_W-1:0]  dividend;
      logic [SIZE_W-1:0] divisor;
   } mod_cmd_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [SLOT_W-1:0] remainder;
   } mod_res_type;

endpackage

@@ sv/lpht_mod_unit.sv @@
// Bit-serial remainder unit: key mod table size, one key bit per cycle
`timescale 1ns / 1ps

module lpht_mod_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  lpht_pkg::mod_cmd_type cmd,
   output lpht_pkg::mod_res_type res
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [lpht_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic [lpht_pkg::KEY_W-1:0]      dvd_ff, dvd_in;
   logic [lpht_pkg::SLOT_W-1:0]     rem_ff, rem_in;
   logic [lpht_pkg::SIZE_W-1:0]     div_ff, div_in;
   logic [lpht_pkg::SIZE_W-1:0]     trial;
   logic [lpht_pkg::SIZE_W-1:0]     diff;

   // Shift in the next key bit and subtract the divisor when it fits
   always_comb begin
      trial = {rem_ff, dvd_ff[lpht_pkg::KEY_W-1]};
      diff  = trial - div_ff;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = lpht_pkg::CNT_W'(lpht_pkg::KEY_W - 1);
         dvd_in  = cmd.dividend;
         rem_in  = '0;
         div_in  = cmd.divisor;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[lpht_pkg::KEY_W-2:0], 1'b0};
         rem_in = (trial >= div_ff) ? diff[lpht_pkg::SLOT_W-1:0]
                                    : trial[lpht_pkg::SLOT_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign res.busy      = busy_ff;
   assign res.done      = done_ff;
   assign res.remainder = rem_ff;

endmodule

@@ sv/lpht_slot_ram.sv @@
// Slot store: key, id and age per slot, one write and one registered read port
`timescale 1ns / 1ps

module lpht_slot_ram (
   input  logic                         clock,
   input  lpht_pkg::ram_wr_type         wr,
   input  logic [lpht_pkg::SLOT_W-1:0]  rd_addr,
   output lpht_pkg::slot_entry_type     rd_data
);

   lpht_pkg::slot_entry_type mem [lpht_pkg::TABLE_DEPTH];
   lpht_pkg::slot_entry_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/linear_probe_hash_table.sv @@
// Steps: accept, then key mod size (the remainder steps and the handoff).
// Insert probes one slot per cycle (valid bits in flops); search and delete probe each slot
// in S_READ (registered slot RAM read), then S_CHECK (compare); S_FINISH loads the output word.
// Fastest paths: search with a free home slot, then insert at its home slot.
// Only one word is in flight; ready again once its result is handed to the output.
// Reset clears all valid bits at once and sets the table size to 256; no clearing pass.
`timescale 1ns / 1ps
`include "linear_probe_hash_table_assert.svh"

module linear_probe_hash_table (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  lpht_pkg::req_word_type         req_word,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output lpht_pkg::rsp_word_type         rsp_word,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [lpht_pkg::SIZE_W-1:0]    csr_data
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_HASH   = 6'b000010,
      S_INSERT = 6'b000100,
      S_READ   = 6'b001000,
      S_CHECK  = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   state_type                         state_ff, state_in;
   logic [lpht_pkg::TABLE_DEPTH-1:0]  valid_ff, valid_in;
   logic [lpht_pkg::SIZE_W-1:0]       table_size_ff, table_size_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   lpht_pkg::rsp_word_type            rsp_ff, rsp_in;
   lpht_pkg::rsp_word_type            res_ff, res_in;
   lpht_pkg::req_word_type            req_ff, req_in;
   logic [lpht_pkg::SIZE_W-1:0]       n_ff, n_in;
   logic [lpht_pkg::SLOT_W-1:0]       s_ff, s_in;
   logic [lpht_pkg::SLOT_W-1:0]       home_ff, home_in;

   logic [lpht_pkg::SIZE_W-1:0]       n_sat;
   logic [lpht_pkg::SIZE_W-1:0]       nxt_wide;
   logic [lpht_pkg::SLOT_W-1:0]       nxt;
   lpht_pkg::mod_cmd_type             mod_cmd;
   lpht_pkg::mod_res_type             mod_res;
   lpht_pkg::ram_wr_type              ram_wr;
   lpht_pkg::slot_entry_type          rd_data;

   lpht_mod_unit u_mod (
      .clock (clock),
      .reset (reset),
      .cmd   (mod_cmd),
      .res   (mod_res)
   );

   lpht_slot_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_addr (s_ff),
      .rd_data (rd_data)
   );

   // Clamp the configured size to 1..TABLE_DEPTH
   always_comb begin
      if (table_size_ff == '0) begin
         n_sat = lpht_pkg::SIZE_W'(1);
      end else if (table_size_ff > lpht_pkg::SIZE_W'(lpht_pkg::TABLE_DEPTH)) begin
         n_sat = lpht_pkg::SIZE_W'(lpht_pkg::TABLE_DEPTH);
      end else begin
         n_sat = table_size_ff;
      end
   end

   // Next probe slot, wrapping at the table size
   always_comb begin
      nxt_wide = {1'b0, s_ff} + lpht_pkg::SIZE_W'(1);
      nxt      = (nxt_wide >= n_ff) ? '0 : nxt_wide[lpht_pkg::SLOT_W-1:0];
   end

   assign req_ready     = (state_ff == S_IDLE);
   assign csr_ready     = 1'b1;
   assign table_size_in = (csr_valid) ? csr_data : table_size_ff;

   // Sequencer
   always_comb begin
      state_in         = state_ff;
      valid_in         = valid_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_in           = rsp_ff;
      res_in           = res_ff;
      req_in           = req_ff;
      n_in             = n_ff;
      s_in             = s_ff;
      home_in          = home_ff;
      mod_cmd.start    = 1'b0;
      mod_cmd.dividend = req_word.key;
      mod_cmd.divisor  = n_sat;
      ram_wr.en        = 1'b0;
      ram_wr.addr      = s_ff;
      ram_wr.data.key  = req_ff.key;
      ram_wr.data.id   = req_ff.id_value;
      ram_wr.data.age  = req_ff.age_value;

      // Drop the output word once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in            = req_word;
               n_in              = n_sat;
               res_in.status     = lpht_pkg::STATUS_MISSING;
               res_in.slot_index = '0;
               res_in.found_id   = '0;
               res_in.found_age  = '0;
               if (req_word.req_type inside {lpht_pkg::REQ_INSERT, lpht_pkg::REQ_SEARCH,
                                             lpht_pkg::REQ_DELETE}) begin
                  mod_cmd.start = 1'b1;
                  state_in      = S_HASH;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_HASH: begin
            if (mod_res.done) begin
               s_in    = mod_res.remainder;
               home_in = mod_res.remainder;
               if (req_ff.req_type == lpht_pkg::REQ_INSERT) begin
                  state_in = S_INSERT;
               end else if (!valid_ff[mod_res.remainder]) begin
                  state_in = S_FINISH;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_INSERT: begin
            // Claim the first free slot, or report full after a whole wrap
            if (!valid_ff[s_ff]) begin
               ram_wr.en         = 1'b1;
               valid_in[s_ff]    = 1'b1;
               res_in.status     = lpht_pkg::STATUS_OK;
               res_in.slot_index = s_ff;
               state_in          = S_FINISH;
            end else if (nxt == home_ff) begin
               res_in.status = lpht_pkg::STATUS_FULL;
               state_in      = S_FINISH;
            end else begin
               s_in = nxt;
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            // Compare the slot just read; free it on delete
            if (valid_ff[s_ff] && (rd_data.key == req_ff.key)) begin
               res_in.status     = lpht_pkg::STATUS_OK;
               res_in.slot_index = s_ff;
               res_in.found_id   = rd_data.id;
               res_in.found_age  = rd_data.age;
               if (req_ff.req_type == lpht_pkg::REQ_DELETE) begin
                  valid_in[s_ff] = 1'b0;
               end
               state_in = S_FINISH;
            end else if (nxt == home_ff) begin
               state_in = S_FINISH;
            end else begin
               s_in     = nxt;
               state_in = S_READ;
            end
         end
         S_FINISH: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         table_size_ff <= lpht_pkg::SIZE_W'(lpht_pkg::TABLE_DEPTH);
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         table_size_ff <= table_size_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      res_ff  <= res_in;
      req_ff  <= req_in;
      n_ff    <= n_in;
      s_ff    <= s_in;
      home_ff <= home_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // Checks
   `LPHT_ASSERT_NOW(a_mod_done_in_hash, clock, reset, mod_res.done, state_ff == S_HASH, "remainder finished outside the hash step")
   `LPHT_ASSERT_NOW(a_idle_mod_quiet, clock, reset, state_ff == S_IDLE, !mod_res.busy, "remainder unit busy while ready for a word")
   `LPHT_ASSERT_NEXT(a_insert_marks, clock, reset, (state_ff == S_INSERT) && !valid_ff[s_ff], valid_ff[$past(s_ff)], "inserted slot not marked valid")
   `LPHT_ASSERT_NEXT(a_finish_loads, clock, reset, (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready), rsp_valid_ff && (rsp_ff == $past(res_ff)), "result not moved to the output word")
   `LPHT_ASSERT_NOW(a_slot_in_range, clock, reset, rsp_valid_ff && (rsp_ff.status == lpht_pkg::STATUS_OK), {1'b0, rsp_ff.slot_index} < n_ff, "reported slot beyond table size")

endmodule

@@ sim/hash_table_checker.sv @@
// Checker for the hash table: tracks the table, predicts each response word and compares it
`timescale 1ns / 1ps

module hash_table_checker
   import lpht_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  req_word_type        req_word,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  rsp_word_type        rsp_word,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [SIZE_W-1:0]   csr_data,
   output int                  fail_count,
   output int                  pending_count
);

   // Shadow copy of the table and its size register
   logic [SIZE_W-1:0] size_reg;
   logic              slot_used [TABLE_DEPTH];
   slot_entry_type    slot_mem  [TABLE_DEPTH];
   rsp_word_type      expected_rsp_q [$];

   // Apply one request to the shadow table and return the response it should give
   function automatic rsp_word_type apply_request(input req_word_type w);
      rsp_word_type r;
      int unsigned  n;
      int unsigned  home;
      int unsigned  s;
      bit           hit;
      r        = '0;
      r.status = STATUS_MISSING;
      // a zero size acts as one slot, anything past the depth saturates
      n = (size_reg == 0) ? 1 : ((size_reg > TABLE_DEPTH) ? TABLE_DEPTH : size_reg);
      home = w.key % n;
      s    = home;
      hit  = 1'b0;
      case (w.req_type)
         REQ_INSERT: begin
            // walk to the first free slot, at most one wrap
            while (slot_used[s]) begin
               s = (s + 1 >= n) ? 0 : s + 1;
               if (s == home) break;
            end
            if (slot_used[s]) begin
               r.status = STATUS_FULL;
            end else begin
               slot_used[s]    = 1'b1;
               slot_mem[s].key = w.key;
               slot_mem[s].id  = w.id_value;
               slot_mem[s].age = w.age_value;
               r.status        = STATUS_OK;
               r.slot_index    = SLOT_W'(s);
            end
         end
         REQ_SEARCH, REQ_DELETE: begin
            // a free home slot ends the lookup at once
            if (slot_used[home]) begin
               do begin
                  if (slot_used[s] && slot_mem[s].key == w.key) hit = 1'b1;
                  else s = (s + 1 >= n) ? 0 : s + 1;
               end while (!hit && s != home);
            end
            if (hit) begin
               r.status     = STATUS_OK;
               r.slot_index = SLOT_W'(s);
               r.found_id   = slot_mem[s].id;
               r.found_age  = slot_mem[s].age;
               if (w.req_type == REQ_DELETE) slot_used[s] = 1'b0;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0d, actual %0d", name, want_v, got_v);
         fail_count++;
      end
   endtask

   // Watch all three channels on the rising edge
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         size_reg = SIZE_W'(TABLE_DEPTH);
         for (int i = 0; i < TABLE_DEPTH; i++) slot_used[i] = 1'b0;
         expected_rsp_q.delete();
      end else begin
         if (csr_valid && csr_ready) size_reg = csr_data;
         // retire the oldest expectation before queuing a new one
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               $error("response word with no request outstanding");
               fail_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_word.status));
               check_field("slot_index", 32'(want.slot_index), 32'(rsp_word.slot_index));
               check_field("found_id", 32'(want.found_id), 32'(rsp_word.found_id));
               check_field("found_age", 32'(want.found_age), 32'(rsp_word.found_age));
            end
         end
         if (req_valid && req_ready) expected_rsp_q.push_back(apply_request(req_word));
      end
      pending_count = expected_rsp_q.size();
   end

endmodule

@@ sim/linear_probe_hash_table_tb.sv @@
// Testbench top for the hash table: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module linear_probe_hash_table_tb;
   import lpht_pkg::*;

   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
   localparam logic [KEY_W-1:0] KEY_TOP    = {KEY_W{1'b1}};

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_word_type        req_word  = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_word_type        rsp_word;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [SIZE_W-1:0]   csr_data  = '0;
   int                  fail_count;
   int                  pending_count;
   bit                  quiet_tail = 1'b0;

   linear_probe_hash_table uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   hash_table_checker u_table_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_word      (rsp_word),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #50_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // Stall the response side in random bursts, none in the tail of the run
   initial begin
      forever begin
         @(negedge clock);
         if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // Offer one request word, with an optional idle burst first, and hold until taken
   task automatic send_request(input logic [REQ_W-1:0] kind, input logic [KEY_W-1:0] key,
                               input logic [ID_W-1:0] id, input logic [AGE_W-1:0] age);
      int gap;
      gap = (!quiet_tail && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_word.req_type  <= kind;
      req_word.key       <= key;
      req_word.id_value  <= id;
      req_word.age_value <= age;
      req_valid          <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and wait until every outstanding response has come back
   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic write_size(input logic [SIZE_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // One random phase: set the size, then mix operations over a pool of colliding keys
   task automatic run_phase(input logic [SIZE_W-1:0] size_value, input int count);
      logic [KEY_W-1:0]  pool [10];
      logic [KEY_W-1:0]  key;
      logic [REQ_W-1:0]  kind;
      int unsigned       n;
      int unsigned       home;
      int                pick;
      drain();
      write_size(size_value);
      n    = (size_value == 0) ? 1 : ((size_value > TABLE_DEPTH) ? TABLE_DEPTH : size_value);
      home = $urandom_range(0, n - 1);
      // low keys share one home slot, high keys another, the rest are anywhere
      for (int i = 0; i < 10; i++) begin
         if (i < 4) pool[i] = KEY_W'(home + i * n);
         else if (i < 7) pool[i] = KEY_TOP - KEY_W'((i - 4) * n);
         else pool[i] = KEY_W'($urandom());
      end
      for (int j = 0; j < count; j++) begin
         key  = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom()) : pool[$urandom_range(0, 9)];
         pick = $urandom_range(0, 99);
         if (pick < 45) kind = REQ_INSERT;
         else if (pick < 75) kind = REQ_SEARCH;
         else if (pick < 95) kind = REQ_DELETE;
         else kind = REQ_UNUSED;
         send_request(kind, key, ID_W'($urandom()), AGE_W'($urandom_range(0, 255)));
         // now and then hold off until the block has answered everything
         if ($urandom_range(0, 39) == 0) drain();
      end
   endtask

   initial begin
      logic [SIZE_W-1:0] sizes [10];
      sizes = '{9'd16, 9'd1, 9'd3, 9'd256, 9'd0, 9'd7, 9'd511, 9'd64, 9'd2, 9'd0};
      sizes[9] = SIZE_W'($urandom_range(0, 511));

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Directed: empty table, collisions, wrap, full wrap miss, freed home slot
      send_request(REQ_SEARCH, '0, '0, '0);
      send_request(REQ_DELETE, KEY_TOP, '0, '0);
      send_request(REQ_INSERT, '0, {ID_W{1'b1}}, 8'hFF);
      send_request(REQ_INSERT, 31'd256, '0, '0);
      send_request(REQ_INSERT, KEY_TOP, 31'h2AAA_AAAA, 8'h55);
      send_request(REQ_INSERT, 31'd511, 31'h5555_5555, 8'hAA);
      send_request(REQ_SEARCH, 31'd256, '0, '0);
      send_request(REQ_SEARCH, 31'd511, '0, '0);
      send_request(REQ_SEARCH, 31'd512, '0, '0);
      send_request(REQ_DELETE, '0, '0, '0);
      send_request(REQ_SEARCH, 31'd256, '0, '0);
      send_request(REQ_UNUSED, 31'd256, 31'h1234_5678, 8'h3C);

      // Single slot: fill, overflow, find, free
      drain();
      write_size(9'd1);
      send_request(REQ_INSERT, 31'd5, 31'd77, 8'd9);
      send_request(REQ_INSERT, 31'd6, 31'd78, 8'd10);
      send_request(REQ_SEARCH, 31'd5, '0, '0);
      send_request(REQ_DELETE, 31'd5, '0, '0);
      send_request(REQ_SEARCH, 31'd5, '0, '0);

      // Size zero acts as one slot
      drain();
      write_size(9'd0);
      send_request(REQ_INSERT, 31'd9, 31'd99, 8'd1);
      send_request(REQ_INSERT, 31'd10, 31'd100, 8'd2);

      // Oversize saturates; old entries are still there
      drain();
      write_size(9'd511);
      send_request(REQ_SEARCH, 31'd256, '0, '0);
      send_request(REQ_SEARCH, 31'd9, '0, '0);
      send_request(REQ_DELETE, KEY_TOP, '0, '0);

      // Random phases; the last two run with no random gaps or response stalls
      for (int p = 0; p < 10; p++) begin
         if (p >= 8) quiet_tail = 1'b1;
         run_phase(sizes[p], 48);
      end

      drain();
      repeat (40) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
